FILE: src/sndir_pkg.sv
// Package with the codes and constants of the short-name directory search.
`default_nettype none
package sndir_pkg;

  localparam int KEY_LEN = 11;
  localparam int KEY_POS_W = 4;
  localparam int INDEX_W = 16;

  localparam logic [KEY_POS_W-1:0] EXT_POS = 4'd8;
  localparam logic [KEY_POS_W-1:0] KEY_END = 4'd11;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DOT_CHAR = 8'h2e;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] SKIP_MASK = 8'h18;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  localparam logic [INDEX_W-1:0] MAX_ENTRIES_RESET = 16'd224;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_CHAR = 2'd1;
  localparam logic [1:0] CMD_ENTRY = 2'd2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FOUND = 2'd1,
    ST_MISS = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

endpackage
`default_nettype wire

FILE: src/short_name_directory_search.sv
// Top level of the short-name (8.3) directory search: key build and entry compare.
// Pipeline: input register then result register; the result register loads when the output is free.
// Throughput: one item per cycle while m_axis_tready holds; the key update and the 11-byte compare with the
//   index update are done combinationally between the two registers.
// Reset: synchronous rst clears both stages, sets the key to spaces, clears the search
//   state and loads max_entries with 224.
`default_nettype none
module short_name_directory_search (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         max_entries_we,
  input  wire logic [15:0]  max_entries_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // name_char[7:0], entry_base[71:8], entry_ext[95:72], entry_type[103:96]
  input  wire logic [103:0] s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // entry_index[15:0]
  output logic [15:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser
);

  logic [sndir_pkg::INDEX_W-1:0] max_entries;

  logic        in_valid;
  logic [1:0]  in_cmd;
  logic [7:0]  in_char;
  logic [63:0] in_base;
  logic [23:0] in_ext;
  logic [7:0]  in_type;

  logic [7:0]                      key [sndir_pkg::KEY_LEN];
  logic [7:0]                      key_next [sndir_pkg::KEY_LEN];
  logic [sndir_pkg::KEY_POS_W-1:0] key_pos;
  logic [sndir_pkg::KEY_POS_W-1:0] key_pos_next;
  logic                            overflow;
  logic                            overflow_next;
  logic                            done;
  logic                            done_next;
  logic [sndir_pkg::INDEX_W-1:0]   cur_index;
  logic [sndir_pkg::INDEX_W-1:0]   cur_index_next;

  logic                          out_valid;
  sndir_pkg::status_t            out_status;
  sndir_pkg::status_t            out_status_next;
  logic [sndir_pkg::INDEX_W-1:0] out_index;
  logic [sndir_pkg::INDEX_W-1:0] out_index_next;

  logic                          out_ready;
  logic                          advance;
  logic                          key_match;
  logic [7:0]                    char_up;
  logic [sndir_pkg::INDEX_W-1:0] index_inc;

  assign out_ready     = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_index;
  assign m_axis_tuser  = out_status;

  assign index_inc = cur_index + 16'd1;

  always_comb begin
    if (in_char >= sndir_pkg::LOWER_A && in_char <= sndir_pkg::LOWER_Z) begin
      char_up = in_char - sndir_pkg::CASE_BIT;
    end else begin
      char_up = in_char;
    end
  end

  always_comb begin
    key_match = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (in_base[63-8*k -: 8] != key[k]) begin
        key_match = 1'b0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (in_ext[23-8*k -: 8] != key[8+k]) begin
        key_match = 1'b0;
      end
    end
  end

  always_comb begin
    key_next        = key;
    key_pos_next    = key_pos;
    overflow_next   = overflow;
    done_next       = done;
    cur_index_next  = cur_index;
    out_status_next = sndir_pkg::ST_IGNORED;
    out_index_next  = cur_index;
    unique case (in_cmd)
      sndir_pkg::CMD_START: begin
        for (int k = 0; k < sndir_pkg::KEY_LEN; k++) begin
          key_next[k] = sndir_pkg::SPACE_CHAR;
        end
        key_pos_next    = '0;
        overflow_next   = 1'b0;
        done_next       = 1'b0;
        cur_index_next  = '0;
        out_status_next = sndir_pkg::ST_OK;
        out_index_next  = '0;
      end
      sndir_pkg::CMD_CHAR: begin
        if (!done) begin
          out_status_next = sndir_pkg::ST_OK;
          if (in_char != sndir_pkg::NUL_CHAR) begin
            if (key_pos >= sndir_pkg::KEY_END) begin
              overflow_next = 1'b1;
            end else if (in_char == sndir_pkg::DOT_CHAR && key_pos <= sndir_pkg::EXT_POS) begin
              key_pos_next = sndir_pkg::EXT_POS;
            end else begin
              key_next[key_pos] = char_up;
              key_pos_next      = key_pos + 4'd1;
            end
          end
        end
      end
      sndir_pkg::CMD_ENTRY: begin
        if (!done) begin
          if (overflow || cur_index >= max_entries || in_base[63:56] == sndir_pkg::NUL_CHAR) begin
            done_next       = 1'b1;
            out_status_next = sndir_pkg::ST_MISS;
          end else if ((in_type & sndir_pkg::SKIP_MASK) == 8'h00 && key_match) begin
            done_next       = 1'b1;
            out_status_next = sndir_pkg::ST_FOUND;
          end else begin
            cur_index_next = index_inc;
            if (index_inc >= max_entries) begin
              done_next       = 1'b1;
              out_status_next = sndir_pkg::ST_MISS;
            end else begin
              out_status_next = sndir_pkg::ST_OK;
            end
          end
        end
      end
      default: begin
        out_status_next = sndir_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= sndir_pkg::MAX_ENTRIES_RESET;
    end else if (max_entries_we) begin
      max_entries <= max_entries_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= s_axis_tuser;
      in_char <= s_axis_tdata[7:0];
      in_base <= s_axis_tdata[71:8];
      in_ext  <= s_axis_tdata[95:72];
      in_type <= s_axis_tdata[103:96];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < sndir_pkg::KEY_LEN; k++) begin
        key[k] <= sndir_pkg::SPACE_CHAR;
      end
      key_pos   <= '0;
      overflow  <= 1'b0;
      done      <= 1'b0;
      cur_index <= '0;
    end else if (advance) begin
      key       <= key_next;
      key_pos   <= key_pos_next;
      overflow  <= overflow_next;
      done      <= done_next;
      cur_index <= cur_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= out_status_next;
      out_index  <= out_index_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/sndir_checker.sv
// Port checker for the short-name directory search, bound to the top level.
`default_nettype none
module sndir_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [15:0]  m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("result or stall present right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while the result side can move");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
    else $error("result carries unknown bits");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

endmodule

bind short_name_directory_search sndir_checker u_sndir_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: sim/tb_short_name_directory_search.sv
// Testbench for the short-name directory search: directed and random searches, checked per result.
module tb_short_name_directory_search;
  import sndir_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_DEPTH = 2;
  localparam int RANDOM_ITEMS = 800;

  // Layout of s_axis_tdata, last member in the lowest bits
  typedef struct packed {
    logic [7:0]  entry_type;
    logic [23:0] entry_ext;
    logic [63:0] entry_base;
    logic [7:0]  name_char;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] index;
  } reply_t;

  typedef enum {E_RANDOM, E_KEY, E_NEAR, E_END} entry_kind_t;

  class dir_lookup_board;
    logic [8*KEY_LEN-1:0] key_word;
    logic [KEY_POS_W-1:0] key_pos;
    bit                   name_too_long;
    bit                   finished;
    logic [INDEX_W-1:0]   entry_no;
    logic [INDEX_W-1:0]   entry_limit;
    reply_t               owed[$];
    int                   errors;
    int                   checked;
    int                   status_seen[4];

    function new();
      entry_limit = MAX_ENTRIES_RESET;
      errors = 0;
      checked = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
      clear_key();
    endfunction

    function void clear_key();
      key_word = {KEY_LEN{SPACE_CHAR}};
      key_pos = '0;
      name_too_long = 1'b0;
      finished = 1'b0;
      entry_no = '0;
    endfunction

    function void append_char(logic [7:0] c);
      int p;
      p = key_pos;
      if (key_pos >= KEY_END) begin
        name_too_long = 1'b1;
      end else if (c == DOT_CHAR && key_pos <= EXT_POS) begin
        key_pos = EXT_POS;
      end else begin
        if (c >= LOWER_A && c <= LOWER_Z) c = c - CASE_BIT;
        key_word[8*KEY_LEN-1-8*p -: 8] = c;
        key_pos = key_pos + 1'b1;
      end
    endfunction

    function void take_item(logic [1:0] cmd, item_t it);
      reply_t r;
      r.status = ST_IGNORED;
      r.index = entry_no;
      case (cmd)
        CMD_START: begin
          clear_key();
          r.status = ST_OK;
          r.index = '0;
        end
        CMD_CHAR: begin
          if (!finished) begin
            if (it.name_char != NUL_CHAR) append_char(it.name_char);
            r.status = ST_OK;
          end
        end
        CMD_ENTRY: begin
          if (!finished) begin
            if (name_too_long || entry_no >= entry_limit ||
                it.entry_base[63:56] == NUL_CHAR) begin
              finished = 1'b1;
              r.status = ST_MISS;
            end else if ((it.entry_type & SKIP_MASK) == 8'h00 &&
                         {it.entry_base, it.entry_ext} == key_word) begin
              finished = 1'b1;
              r.status = ST_FOUND;
            end else begin
              entry_no = entry_no + 1'b1;
              if (entry_no >= entry_limit) begin
                finished = 1'b1;
                r.status = ST_MISS;
              end else begin
                r.status = ST_OK;
              end
            end
          end
        end
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [INDEX_W-1:0] index);
      reply_t w;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing pending, status %0d index %0d",
                 $time, status, index);
        errors++;
        return;
      end
      w = owed.pop_front();
      checked++;
      status_seen[w.status]++;
      if (status !== w.status) begin
        $display("%0t: status expected %0d got %0d", $time, w.status, status);
        errors++;
      end
      if (index !== w.index) begin
        $display("%0t: entry_index expected %0d got %0d", $time, w.index, index);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         max_entries_we = 1'b0;
  logic [15:0]  max_entries_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = CMD_START;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  dir_lookup_board board = new();
  bit gaps_on = 1'b1;
  int stall_left = 0;
  int idle_cycles = 0;
  int items_in = 0;
  int sent = 0;

  short_name_directory_search dut (
    .clk(clk),
    .rst(rst),
    .max_entries_we(max_entries_we),
    .max_entries_wdata(max_entries_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        board.take_item(s_axis_tuser, item_t'(s_axis_tdata));
        items_in++;
      end
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tuser, m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_short_name_directory_search NOT OK");
        $finish;
      end
    end
  end

  function automatic item_t rand_item();
    item_t it;
    it.name_char = 8'($urandom);
    it.entry_base = {$urandom, $urandom};
    it.entry_ext = 24'($urandom);
    it.entry_type = 8'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("A", "Z"));
      1: return 8'($urandom_range("a", "z"));
      2: return 8'($urandom_range("0", "9"));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_attr();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom) & ~SKIP_MASK;
  endfunction

  // Take key bytes at drive time so the entry sees every earlier item
  task automatic push_item(logic [1:0] cmd, item_t it, bit from_key = 1'b0, int flip = -1);
    logic [8*KEY_LEN-1:0] kw;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    if (from_key) begin
      kw = board.key_word;
      if (flip >= 0)
        kw[8*KEY_LEN-1-8*flip -: 8] = kw[8*KEY_LEN-1-8*flip -: 8] ^ 8'($urandom_range(1, 255));
      {it.entry_base, it.entry_ext} = kw;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= it;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    push_item(cmd, rand_item());
  endtask

  task automatic send_char(logic [7:0] c);
    item_t it;
    it = rand_item();
    it.name_char = c;
    push_item(CMD_CHAR, it);
  endtask

  task automatic send_entry(entry_kind_t kind, logic [7:0] attr);
    item_t it;
    it = rand_item();
    it.entry_type = attr;
    if (kind == E_END) it.entry_base[63:56] = NUL_CHAR;
    push_item(CMD_ENTRY, it, kind == E_KEY || kind == E_NEAR,
              kind == E_NEAR ? int'($urandom_range(0, KEY_LEN - 1)) : -1);
  endtask

  // Drain the pipe, then write the limit
  task automatic set_limit(logic [15:0] v);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    @(negedge clk);
    max_entries_we <= 1'b1;
    max_entries_wdata <= v;
    @(negedge clk);
    max_entries_we <= 1'b0;
    board.entry_limit = v;
  endtask

  task automatic run_search();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) push_item(2'($urandom_range(0, 3)), rand_item());
      return;
    end
    send_cmd(CMD_START);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(9, 14)) send_char(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 8)) send_char(pick_name_char());
      if ($urandom_range(0, 3) != 0) begin
        send_char(DOT_CHAR);
        repeat ($urandom_range(0, 3)) send_char(pick_name_char());
      end
    end
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 19))
        0: send_entry(E_END, pick_attr());
        1: send_char(pick_name_char());
        2: send_cmd(CMD_UNUSED);
        3, 4, 5: send_entry(E_KEY, pick_attr());
        6, 7, 8: send_entry(E_NEAR, pick_attr());
        default: send_entry(E_RANDOM, pick_attr());
      endcase
    end
  endtask

  initial begin : stimulus
    item_t it;
    logic [15:0] limits [6];
    int goal;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_cmd(CMD_START);
    send_char("r");
    send_char(NUL_CHAR);
    send_char(DOT_CHAR);
    send_char("z");
    it = '1;
    it.entry_type = 8'h00;
    push_item(CMD_ENTRY, it);
    // dot past the extension start is kept as a character
    send_char(DOT_CHAR);
    send_char(8'hff);
    send_entry(E_KEY, 8'h08);
    send_entry(E_KEY, 8'h10);
    send_entry(E_KEY, ~SKIP_MASK);
    send_char("q");
    send_entry(E_KEY, 8'h00);
    send_cmd(CMD_UNUSED);
    send_cmd(CMD_START);
    push_item(CMD_ENTRY, '0);
    send_cmd(CMD_START);
    send_char(DOT_CHAR);
    send_char("a");
    send_char(8'h01);
    send_char("c");
    send_char("d");
    send_entry(E_KEY, 8'h00);
    send_cmd(CMD_START);
    send_char("x");
    send_entry(E_RANDOM, 8'h00);
    send_entry(E_RANDOM, 8'h00);
    // lower the limit below the running index
    set_limit(16'd1);
    send_entry(E_KEY, 8'h00);
    set_limit(16'd0);
    send_cmd(CMD_START);
    send_entry(E_KEY, 8'h00);

    limits = '{16'd65535, 16'd3, MAX_ENTRIES_RESET, 16'd1,
               16'($urandom_range(2, 40)), 16'd12};
    goal = sent;
    foreach (limits[p]) begin
      set_limit(limits[p]);
      if (p == $size(limits) - 1) gaps_on <= 1'b0;
      goal += RANDOM_ITEMS / $size(limits);
      while (sent < goal) run_search();
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    @(negedge clk);
    $display("%0d items in, %0d results checked: %0d found, %0d not found, %0d ignored",
             items_in, board.checked, board.status_seen[ST_FOUND],
             board.status_seen[ST_MISS], board.status_seen[ST_IGNORED]);
    $display("entry limits 0, 1, 3, 12, 224, 65535 and one random value; %0d errors",
             board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_short_name_directory_search OK");
    end else begin
      $display("tb_short_name_directory_search NOT OK");
    end
    $finish;
  end

endmodule
